FILE: rtl/cbsc_pkg.sv
// shared constants for the core busy sample counter
`default_nettype none

package cbsc_pkg;

  // width of the sleep mask field, one bit per core
  localparam int unsigned MaskW = 18;
  // width of a busy counter and of the sample counter
  localparam int unsigned CntW = 16;
  // width of the core index result field
  localparam int unsigned CoreIdxW = 5;
  // default number of cores
  localparam int unsigned CoreCountDef = 18;
  // entries in the queue between front and back, a power of two
  localparam int unsigned QueueDepthDef = 4;

  localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};
  localparam logic [CntW-1:0] LimitRst = CntW'(1);

endpackage

`default_nettype wire

FILE: rtl/cbsc_front.sv
// front end: accepts mask samples, turns them into busy vectors, queues them
`default_nettype none

module cbsc_front #(
  parameter int unsigned CORE_COUNT  = cbsc_pkg::CoreCountDef,
  parameter int unsigned QUEUE_DEPTH = cbsc_pkg::QueueDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [cbsc_pkg::MaskW-1:0]   sleep_mask_i,
  output logic                              head_valid_o,
  output logic [CORE_COUNT-1:0]             head_busy_o,
  input  wire logic                         pop_i
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [CORE_COUNT-1:0] busy_vec;
  logic [CORE_COUNT-1:0] queue_q [QUEUE_DEPTH];
  logic [PtrW:0]         wr_ptr_q, wr_ptr_d;
  logic [PtrW:0]         rd_ptr_q, rd_ptr_d;
  logic                  empty, full, push;

  // a clear mask bit means busy; cores past the mask width are always busy
  for (genvar i = 0; i < CORE_COUNT; i++) begin : g_cls
    if (i < cbsc_pkg::MaskW) begin : g_in
      assign busy_vec[i] = ~sleep_mask_i[i];
    end else begin : g_out
      assign busy_vec[i] = 1'b1;
    end
  end

  assign empty = (wr_ptr_q == rd_ptr_q);
  assign full  = (wr_ptr_q[PtrW-1:0] == rd_ptr_q[PtrW-1:0]) &&
                 (wr_ptr_q[PtrW] != rd_ptr_q[PtrW]);

  assign in_ready_o   = ~full;
  assign push         = in_valid_i & ~full;
  assign head_valid_o = ~empty;
  assign head_busy_o  = queue_q[rd_ptr_q[PtrW-1:0]];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = (pop_i && !empty) ? rd_ptr_q + 1'b1 : rd_ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q[PtrW-1:0]] <= busy_vec;
    end
  end

`ifndef ASSERT_OFF
  // queue never pops while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty)
    else $error("pop from empty queue");
  // pointer distance never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) <= (PtrW+1)'(QUEUE_DEPTH))
    else $error("queue occupancy out of range");
  // a refused push leaves the write pointer alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && full) |=> (wr_ptr_q == $past(wr_ptr_q)))
    else $error("write pointer moved while full");
`endif

endmodule

`default_nettype wire

FILE: rtl/cbsc_back.sv
// back end: busy counters, sample count, record snapshot and result drain
`default_nettype none

module cbsc_back #(
  parameter int unsigned CORE_COUNT = cbsc_pkg::CoreCountDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [cbsc_pkg::CntW-1:0]      cfg_data_i,
  input  wire logic                           head_valid_i,
  input  wire logic [CORE_COUNT-1:0]          head_busy_i,
  output logic                                pop_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [cbsc_pkg::CoreIdxW-1:0]       core_index_o,
  output logic [cbsc_pkg::CntW-1:0]           busy_count_o,
  output logic                                last_of_record_o
);

  localparam int unsigned IdxW = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
  localparam logic [IdxW-1:0] IdxLast = IdxW'(CORE_COUNT - 1);

  logic [cbsc_pkg::CntW-1:0] limit_q, limit_d;
  logic [cbsc_pkg::CntW-1:0] cnt_q [CORE_COUNT];
  logic [cbsc_pkg::CntW-1:0] cnt_d [CORE_COUNT];
  logic [cbsc_pkg::CntW-1:0] cnt_inc [CORE_COUNT];
  logic [cbsc_pkg::CntW-1:0] snap_q [CORE_COUNT];
  logic [cbsc_pkg::CntW-1:0] snap_d [CORE_COUNT];
  logic [cbsc_pkg::CntW-1:0] samples_q, samples_d, samples_inc, limit_eff;
  logic                      draining_q, draining_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic                      out_valid_q, out_valid_d;
  logic [cbsc_pkg::CoreIdxW-1:0] core_index_q, core_index_d;
  logic [cbsc_pkg::CntW-1:0] busy_count_q, busy_count_d;
  logic                      last_q, last_d;
  logic                      out_free, drain_fire, drain_last, pop, record_hit;

  assign out_free   = ~out_valid_q | out_ready_i;
  assign drain_fire = draining_q & out_free;
  assign drain_last = (idx_q == IdxLast);
  // next sample may enter in the cycle the last result of a record leaves the snapshot
  assign pop        = head_valid_i & (~draining_q | (drain_fire & drain_last));
  assign pop_o      = pop;

  assign limit_eff   = (limit_q == '0) ? cbsc_pkg::CntW'(1) : limit_q;
  assign samples_inc = (samples_q == cbsc_pkg::CntMax) ? samples_q
                                                       : samples_q + 1'b1;
  assign record_hit  = (samples_inc >= limit_eff);

  always_comb begin
    for (int i = 0; i < CORE_COUNT; i++) begin
      cnt_inc[i] = (head_busy_i[i] && cnt_q[i] != cbsc_pkg::CntMax) ?
                   cnt_q[i] + 1'b1 : cnt_q[i];
    end
  end

  always_comb begin
    limit_d      = cfg_valid_i ? cfg_data_i : limit_q;
    cnt_d        = cnt_q;
    snap_d       = snap_q;
    samples_d    = samples_q;
    draining_d   = draining_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    core_index_d = core_index_q;
    busy_count_d = busy_count_q;
    last_d       = last_q;

    // drain one result per cycle from the head of the snapshot while the output is free
    if (drain_fire) begin
      out_valid_d  = 1'b1;
      core_index_d = cbsc_pkg::CoreIdxW'(idx_q);
      busy_count_d = snap_q[0];
      last_d       = drain_last;
      for (int i = 0; i < CORE_COUNT - 1; i++) begin
        snap_d[i] = snap_q[i+1];
      end
      snap_d[CORE_COUNT-1] = '0;
      if (drain_last) begin
        draining_d = 1'b0;
        idx_d      = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end

    // take one sample; on a record boundary move counts to the snapshot
    if (pop) begin
      if (record_hit) begin
        snap_d     = cnt_inc;
        for (int i = 0; i < CORE_COUNT; i++) begin
          cnt_d[i] = '0;
        end
        samples_d  = '0;
        draining_d = 1'b1;
        idx_d      = '0;
      end else begin
        cnt_d     = cnt_inc;
        samples_d = samples_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q     <= cbsc_pkg::LimitRst;
      for (int i = 0; i < CORE_COUNT; i++) begin
        cnt_q[i] <= '0;
      end
      samples_q   <= '0;
      draining_q  <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      limit_q     <= limit_d;
      cnt_q       <= cnt_d;
      samples_q   <= samples_d;
      draining_q  <= draining_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    snap_q       <= snap_d;
    core_index_q <= core_index_d;
    busy_count_q <= busy_count_d;
    last_q       <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign core_index_o     = core_index_q;
  assign busy_count_o     = busy_count_q;
  assign last_of_record_o = last_q;

`ifndef ASSERT_OFF
  // the flagged result always belongs to the final core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_record_o) |->
      (core_index_o == cbsc_pkg::CoreIdxW'(CORE_COUNT - 1)))
    else $error("last flag on wrong core");
  // sample count stays cleared while a record drains
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    draining_q |-> (samples_q == '0))
    else $error("samples counted during drain");
  // drain index rests at zero between records
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !draining_q |-> (idx_q == '0))
    else $error("drain index not parked");
  // a record boundary always starts a drain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && record_hit) |=> draining_q)
    else $error("record boundary without drain");
`endif

endmodule

`default_nettype wire

FILE: rtl/core_busy_sample_counter_top.sv
// top level of the core busy sample counter
`default_nettype none

// Core busy sample counter. Each input transaction is one sleep-mask sample
// (a set bit means that core sleeps); every core whose bit is clear gets one
// added to its 16-bit busy counter (saturating), and the sample count goes up
// by one. When the sample count reaches samples_per_record (0 acts as 1),
// CORE_COUNT result transactions follow in core order, carrying each core's
// busy count, the last one flagged with last_of_record_o; counters then
// restart from zero. The front end accepts one sample per cycle while its
// QUEUE_DEPTH-entry queue is not full, and the back end absorbs one sample per
// cycle between records. Results are emitted one per cycle, while the output
// register is free, from a snapshot shift register, and the next sample is
// taken in the cycle the final result of a record moves from the snapshot to
// the output register. Cores beyond the 18-bit mask count as busy on every
// sample. samples_per_record is written through its own channel, always
// ready, and resets to 1; the user must write it only while the block is
// idle, which the block itself does not enforce.

module core_busy_sample_counter_top #(
  parameter int unsigned CORE_COUNT  = cbsc_pkg::CoreCountDef,
  parameter int unsigned QUEUE_DEPTH = cbsc_pkg::QueueDepthDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration write channel
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cbsc_pkg::CntW-1:0]     samples_per_record_i,
  // sample input channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [cbsc_pkg::MaskW-1:0]    sleep_mask_i,
  // result output channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [cbsc_pkg::CoreIdxW-1:0]      core_index_o,
  output logic [cbsc_pkg::CntW-1:0]          busy_count_o,
  output logic                               last_of_record_o
);

  logic                  head_valid;
  logic [CORE_COUNT-1:0] head_busy;
  logic                  pop;

  // register writes never stall
  assign cfg_ready_o = 1'b1;

  // front end: mask to busy vector, then into the queue
  cbsc_front #(
    .CORE_COUNT  (CORE_COUNT),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sleep_mask_i (sleep_mask_i),
    .head_valid_o (head_valid),
    .head_busy_o  (head_busy),
    .pop_i        (pop)
  );

  // back end: counting, record snapshot and result drain
  cbsc_back #(
    .CORE_COUNT (CORE_COUNT)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (samples_per_record_i),
    .head_valid_i     (head_valid),
    .head_busy_i      (head_busy),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .core_index_o     (core_index_o),
    .busy_count_o     (busy_count_o),
    .last_of_record_o (last_of_record_o)
  );

endmodule

`default_nettype wire
